[design/assert_macros.svh]
// Assertion macros used by the checker module.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Clocked implication with a fixed delay, disabled while reset is asserted.
`define ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
    else $error("assertion failed");

`endif

[design/hsv2rgb_pkg.sv]
// Shared types and constants for the HSV to RGB pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package hsv2rgb_pkg;

  localparam int HUE_BITS          = 9;
  localparam int CHANNEL_BITS_DEF  = 8;
  localparam int T_BITS            = 6;
  localparam int SECTOR_DEG        = 60;
  localparam int HUE_LIMIT         = 359;
  localparam int PIPE_LATENCY      = 5;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    logic              valid;
    logic              hue_invalid;
    sector_t           sector;
    logic [T_BITS-1:0] t;
  } ctl_t;

endpackage

`default_nettype wire

[design/hsv2rgb_min.sv]
// Stages 1-2: hue sector decode, v*(FS-s) product and exact divide by FS.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_min import hsv2rgb_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic [HUE_BITS-1:0]     hue,
  input  wire logic [CHANNEL_BITS-1:0] sat,
  input  wire logic [CHANNEL_BITS-1:0] bri,
  output ctl_t                         ctl_o,
  output logic [CHANNEL_BITS-1:0]      max_o,
  output logic [CHANNEL_BITS-1:0]      min_o,
  output logic [CHANNEL_BITS-1:0]      span_o
);

  localparam int N = CHANNEL_BITS;
  localparam logic [N-1:0] CH_FULL = '1;

  // stage 1
  sector_t              sector;
  logic [HUE_BITS-1:0]  base;
  logic [HUE_BITS-1:0]  off;
  logic [T_BITS-1:0]    t;
  ctl_t                 ctl1_r, ctl1_nxt;
  logic [N-1:0]         v1_r;
  logic [2*N-1:0]       p1_r;

  // stage 2
  logic [2*N:0]         sum;
  logic [N:0]           q0;
  logic [2*N:0]         q0_fs;
  logic [2*N:0]         rem;
  logic [N-1:0]         mn;
  ctl_t                 ctl2_r;
  logic [N-1:0]         v2_r, mn2_r, d2_r;

  always_comb begin
    priority if (hue >= HUE_BITS'(5 * SECTOR_DEG)) begin
      sector = SEC_MR;
      base   = HUE_BITS'(5 * SECTOR_DEG);
    end else if (hue >= HUE_BITS'(4 * SECTOR_DEG)) begin
      sector = SEC_BM;
      base   = HUE_BITS'(4 * SECTOR_DEG);
    end else if (hue >= HUE_BITS'(3 * SECTOR_DEG)) begin
      sector = SEC_CB;
      base   = HUE_BITS'(3 * SECTOR_DEG);
    end else if (hue >= HUE_BITS'(2 * SECTOR_DEG)) begin
      sector = SEC_GC;
      base   = HUE_BITS'(2 * SECTOR_DEG);
    end else if (hue >= HUE_BITS'(SECTOR_DEG)) begin
      sector = SEC_YG;
      base   = HUE_BITS'(SECTOR_DEG);
    end else begin
      sector = SEC_RY;
      base   = '0;
    end
    off = hue - base;
    // rising ramp in even sectors, falling in odd ones
    t = sector[0] ? (T_BITS'(SECTOR_DEG) - off[T_BITS-1:0]) : off[T_BITS-1:0];
    ctl1_nxt.valid       = in_valid;
    ctl1_nxt.hue_invalid = (hue > HUE_BITS'(HUE_LIMIT));
    ctl1_nxt.sector      = sector;
    ctl1_nxt.t           = t;
  end

  // divide by 2^N-1: estimate, then one correction
  always_comb begin
    sum   = {1'b0, p1_r} + {{(N+1){1'b0}}, p1_r[2*N-1:N]};
    q0    = sum[2*N:N];
    q0_fs = ({q0, {N{1'b0}}}) - {{N{1'b0}}, q0};
    rem   = {1'b0, p1_r} - q0_fs;
    mn    = (rem >= {{(N+1){1'b0}}, CH_FULL}) ? (q0[N-1:0] + N'(1)) : q0[N-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.valid <= 1'b0;
      ctl2_r.valid <= 1'b0;
    end else begin
      ctl1_r.valid <= ctl1_nxt.valid;
      ctl2_r.valid <= ctl1_r.valid;
    end
    ctl1_r.hue_invalid <= ctl1_nxt.hue_invalid;
    ctl1_r.sector      <= ctl1_nxt.sector;
    ctl1_r.t           <= ctl1_nxt.t;
    v1_r               <= bri;
    p1_r               <= bri * (CH_FULL - sat);
    ctl2_r.hue_invalid <= ctl1_r.hue_invalid;
    ctl2_r.sector      <= ctl1_r.sector;
    ctl2_r.t           <= ctl1_r.t;
    v2_r               <= v1_r;
    mn2_r              <= mn;
    d2_r               <= v1_r - mn;
  end

  assign ctl_o  = ctl2_r;
  assign max_o  = v2_r;
  assign min_o  = mn2_r;
  assign span_o = d2_r;

endmodule

`default_nettype wire

[design/hsv2rgb_rise.sv]
// Stages 3-4: span*t product and reciprocal estimate of the divide by 60.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_rise import hsv2rgb_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ctl_t                           ctl_i,
  input  wire logic [CHANNEL_BITS-1:0]        max_i,
  input  wire logic [CHANNEL_BITS-1:0]        min_i,
  input  wire logic [CHANNEL_BITS-1:0]        span_i,
  output ctl_t                                ctl_o,
  output logic [CHANNEL_BITS-1:0]             max_o,
  output logic [CHANNEL_BITS-1:0]             min_o,
  output logic [CHANNEL_BITS+T_BITS-1:0]      prod_o,
  output logic [CHANNEL_BITS-1:0]             est_o
);

  localparam int N = CHANNEL_BITS;
  localparam int K = CHANNEL_BITS + T_BITS;
  localparam logic [K-1:0] RECIP = K'((64'd1 << K) / SECTOR_DEG);

  ctl_t           ctl3_r, ctl4_r;
  logic [N-1:0]   v3_r, mn3_r, v4_r, mn4_r;
  logic [K-1:0]   p2_r, p4_r;
  logic [2*K-1:0] scaled;
  logic [N-1:0]   est4_r;

  assign scaled = p2_r * RECIP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r.valid <= 1'b0;
      ctl4_r.valid <= 1'b0;
    end else begin
      ctl3_r.valid <= ctl_i.valid;
      ctl4_r.valid <= ctl3_r.valid;
    end
    ctl3_r.hue_invalid <= ctl_i.hue_invalid;
    ctl3_r.sector      <= ctl_i.sector;
    ctl3_r.t           <= ctl_i.t;
    v3_r               <= max_i;
    mn3_r              <= min_i;
    p2_r               <= span_i * ctl_i.t;
    ctl4_r.hue_invalid <= ctl3_r.hue_invalid;
    ctl4_r.sector      <= ctl3_r.sector;
    ctl4_r.t           <= ctl3_r.t;
    v4_r               <= v3_r;
    mn4_r              <= mn3_r;
    p4_r               <= p2_r;
    est4_r             <= scaled[K+N-1:K];
  end

  assign ctl_o  = ctl4_r;
  assign max_o  = v4_r;
  assign min_o  = mn4_r;
  assign prod_o = p4_r;
  assign est_o  = est4_r;

endmodule

`default_nettype wire

[design/hsv2rgb_mux.sv]
// Stage 5: quotient correction, mid level and sector channel select.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_mux import hsv2rgb_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ctl_t                           ctl_i,
  input  wire logic [CHANNEL_BITS-1:0]        max_i,
  input  wire logic [CHANNEL_BITS-1:0]        min_i,
  input  wire logic [CHANNEL_BITS+T_BITS-1:0] prod_i,
  input  wire logic [CHANNEL_BITS-1:0]        est_i,
  output logic                                valid_o,
  output logic [CHANNEL_BITS-1:0]             red_o,
  output logic [CHANNEL_BITS-1:0]             green_o,
  output logic [CHANNEL_BITS-1:0]             blue_o,
  output logic                                hue_invalid_o
);

  localparam int N = CHANNEL_BITS;
  localparam int K = CHANNEL_BITS + T_BITS;

  logic [K-1:0] est_x60;
  logic [K-1:0] rem;
  logic [N-1:0] rise;
  logic [N-1:0] mid;
  logic [N-1:0] r_nxt, g_nxt, b_nxt;
  logic         valid_r;
  logic [N-1:0] red_r, green_r, blue_r;
  logic         inv_r;

  always_comb begin
    est_x60 = {est_i, 6'b0} - {4'b0, est_i, 2'b0};
    rem     = prod_i - est_x60;
    rise    = (rem >= K'(SECTOR_DEG)) ? (est_i + N'(1)) : est_i;
    mid     = rise + min_i;
    unique case (ctl_i.sector)
      SEC_RY: begin r_nxt = max_i; g_nxt = mid;   b_nxt = min_i; end
      SEC_YG: begin r_nxt = mid;   g_nxt = max_i; b_nxt = min_i; end
      SEC_GC: begin r_nxt = min_i; g_nxt = max_i; b_nxt = mid;   end
      SEC_CB: begin r_nxt = min_i; g_nxt = mid;   b_nxt = max_i; end
      SEC_BM: begin r_nxt = mid;   g_nxt = min_i; b_nxt = max_i; end
      default: begin r_nxt = max_i; g_nxt = min_i; b_nxt = mid;  end
    endcase
    if (ctl_i.hue_invalid) begin
      r_nxt = '0;
      g_nxt = '0;
      b_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= r_nxt;
    green_r <= g_nxt;
    blue_r  <= b_nxt;
    inv_r   <= ctl_i.hue_invalid;
  end

  assign valid_o       = valid_r;
  assign red_o         = red_r;
  assign green_o       = green_r;
  assign blue_o        = blue_r;
  assign hue_invalid_o = inv_r;

endmodule

`default_nettype wire

[design/hsv_to_rgb_converter.sv]
// HSV to RGB converter, five-stage pipeline; one pixel accepted per cycle.
// out_valid strobes when the accepted beat leaves the last stage.
// Throughput: 1 beat per cycle; busy is low at all times except during reset
// and the first cycle after it. Results are not back-pressured.
// Reset (rst_n, synchronous) clears the valid bits of all stages.
// Depends on hsv2rgb_pkg, hsv2rgb_min, hsv2rgb_rise, hsv2rgb_mux.
`default_nettype none

module hsv_to_rgb_converter import hsv2rgb_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [HUE_BITS-1:0]     in_hue,
  input  wire logic [CHANNEL_BITS-1:0] in_saturation,
  input  wire logic [CHANNEL_BITS-1:0] in_brightness,
  output logic                         out_valid,
  output logic [CHANNEL_BITS-1:0]      out_red,
  output logic [CHANNEL_BITS-1:0]      out_green,
  output logic [CHANNEL_BITS-1:0]      out_blue,
  output logic                         out_hue_invalid
);

  localparam int N = CHANNEL_BITS;

  logic                busy_r;
  logic                accept;
  ctl_t                ctl_a, ctl_b;
  logic [N-1:0]        max_a, min_a, span_a, max_b, min_b, est_b;
  logic [N+T_BITS-1:0] prod_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  hsv2rgb_min #(.CHANNEL_BITS(CHANNEL_BITS)) u_min (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .hue      (in_hue),
    .sat      (in_saturation),
    .bri      (in_brightness),
    .ctl_o    (ctl_a),
    .max_o    (max_a),
    .min_o    (min_a),
    .span_o   (span_a)
  );

  hsv2rgb_rise #(.CHANNEL_BITS(CHANNEL_BITS)) u_rise (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_a),
    .max_i  (max_a),
    .min_i  (min_a),
    .span_i (span_a),
    .ctl_o  (ctl_b),
    .max_o  (max_b),
    .min_o  (min_b),
    .prod_o (prod_b),
    .est_o  (est_b)
  );

  hsv2rgb_mux #(.CHANNEL_BITS(CHANNEL_BITS)) u_mux (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl_i         (ctl_b),
    .max_i         (max_b),
    .min_i         (min_b),
    .prod_i        (prod_b),
    .est_i         (est_b),
    .valid_o       (out_valid),
    .red_o         (out_red),
    .green_o       (out_green),
    .blue_o        (out_blue),
    .hue_invalid_o (out_hue_invalid)
  );

endmodule

`default_nettype wire

[design/hsv2rgb_checker.sv]
// Port-level checker for hsv_to_rgb_converter, bound to the top level.
// Depends on hsv2rgb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hsv2rgb_checker import hsv2rgb_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic [HUE_BITS-1:0]     in_hue,
  input wire logic [CHANNEL_BITS-1:0] in_brightness,
  input wire logic                    out_valid,
  input wire logic [CHANNEL_BITS-1:0] out_red,
  input wire logic [CHANNEL_BITS-1:0] out_green,
  input wire logic [CHANNEL_BITS-1:0] out_blue,
  input wire logic                    out_hue_invalid
);

  logic acc;
  assign acc = start & ~busy;

  `ASSERT_DELAY(a_beat_out, clk, rst_n, acc, PIPE_LATENCY, out_valid)
  `ASSERT_IMPL(a_no_spurious, clk, rst_n, out_valid, $past(acc, PIPE_LATENCY))
  `ASSERT_IMPL(a_flag, clk, rst_n, out_valid, out_hue_invalid == ($past(in_hue, PIPE_LATENCY) > HUE_BITS'(HUE_LIMIT)))
  `ASSERT_IMPL(a_zero, clk, rst_n, out_valid && out_hue_invalid, (out_red == '0) && (out_green == '0) && (out_blue == '0))
  `ASSERT_IMPL(a_max, clk, rst_n, out_valid && !out_hue_invalid, (out_red == $past(in_brightness, PIPE_LATENCY)) || (out_green == $past(in_brightness, PIPE_LATENCY)) || (out_blue == $past(in_brightness, PIPE_LATENCY)))

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_hue          (in_hue),
  .in_brightness   (in_brightness),
  .out_valid       (out_valid),
  .out_red         (out_red),
  .out_green       (out_green),
  .out_blue        (out_blue),
  .out_hue_invalid (out_hue_invalid)
);

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for hsv_to_rgb_converter: directed corners, then random pixel streams.
// An integer predictor computes each expected beat, and a monitor compares every result strobe.
// Depends on hsv2rgb_pkg and the hsv_to_rgb_converter RTL.
`timescale 1ns / 100ps

module tb_top;
  import hsv2rgb_pkg::*;

  localparam int CB = CHANNEL_BITS_DEF;
  localparam int FULL_SCALE = (1 << CB) - 1;
  localparam int HUE_MAX = (1 << HUE_BITS) - 1;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 2 * PIPE_LATENCY + 4;

  typedef struct {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
    logic          hue_invalid;
  } rgb_pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [HUE_BITS-1:0] in_hue = '0;
  logic [CB-1:0] in_saturation = '0;
  logic [CB-1:0] in_brightness = '0;
  logic busy;
  logic out_valid;
  logic [CB-1:0] out_red;
  logic [CB-1:0] out_green;
  logic [CB-1:0] out_blue;
  logic out_hue_invalid;

  rgb_pixel_t pending_rgb[$];
  int err_count = 0;
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  hsv_to_rgb_converter #(.CHANNEL_BITS(CB)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_hue(in_hue),
    .in_saturation(in_saturation),
    .in_brightness(in_brightness),
    .out_valid(out_valid),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .out_hue_invalid(out_hue_invalid)
  );

  function automatic rgb_pixel_t hsv_to_rgb(input logic [HUE_BITS-1:0] h,
                                            input logic [CB-1:0] s,
                                            input logic [CB-1:0] v);
    rgb_pixel_t px;
    int hi, mx, mn, rem, gap, t, mid;
    logic [CB-1:0] cmx, cmn, cmid;
    sector_t sec;
    hi = int'(h);
    px.red = '0;
    px.green = '0;
    px.blue = '0;
    px.hue_invalid = 1'b0;
    if (hi > HUE_LIMIT) begin
      px.hue_invalid = 1'b1;
      return px;
    end
    mx = int'(v);
    mn = (v * (FULL_SCALE - s)) / FULL_SCALE;
    rem = hi % (2 * SECTOR_DEG);
    gap = (rem >= SECTOR_DEG) ? (rem - SECTOR_DEG) : (SECTOR_DEG - rem);
    t = SECTOR_DEG - gap;
    mid = ((mx - mn) * t) / SECTOR_DEG + mn;
    cmx = CB'(mx);
    cmn = CB'(mn);
    cmid = CB'(mid);
    sec = sector_t'(hi / SECTOR_DEG);
    case (sec)
      SEC_RY: begin px.red = cmx;  px.green = cmid; px.blue = cmn;  end
      SEC_YG: begin px.red = cmid; px.green = cmx;  px.blue = cmn;  end
      SEC_GC: begin px.red = cmn;  px.green = cmx;  px.blue = cmid; end
      SEC_CB: begin px.red = cmn;  px.green = cmid; px.blue = cmx;  end
      SEC_BM: begin px.red = cmid; px.green = cmn;  px.blue = cmx;  end
      default: begin px.red = cmx; px.green = cmn;  px.blue = cmid; end
    endcase
    return px;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // input beat accepted: queue its prediction
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      pending_rgb.push_back(hsv_to_rgb(in_hue, in_saturation, in_brightness));
  end

  // result beat check
  always @(posedge clk) begin
    rgb_pixel_t want;
    if (rst_n && out_valid) begin
      if (pending_rgb.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = pending_rgb.pop_front();
        if (out_red !== want.red)
          report_mismatch("red", int'(out_red), int'(want.red));
        if (out_green !== want.green)
          report_mismatch("green", int'(out_green), int'(want.green));
        if (out_blue !== want.blue)
          report_mismatch("blue", int'(out_blue), int'(want.blue));
        if (out_hue_invalid !== want.hue_invalid)
          report_mismatch("hue_invalid", int'(out_hue_invalid), int'(want.hue_invalid));
      end
    end
  end

  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_valid)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic push_pixel(input int h, input int s, input int v);
    in_hue <= HUE_BITS'(h);
    in_saturation <= CB'(s);
    in_brightness <= CB'(v);
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // start low for one cycle, fields scrambled so ignored inputs get exercised
  task automatic skip_cycle();
    start <= 1'b0;
    in_hue <= HUE_BITS'($urandom);
    in_saturation <= CB'($urandom);
    in_brightness <= CB'($urandom);
    @(posedge clk);
  endtask

  // drop start and wait for the next edge first so the last accepted beat is already queued
  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_rgb.size() != 0) @(posedge clk);
  endtask

  task automatic push_random_pixel(input int idle_pct);
    int pick, h, s, v;
    while ($urandom_range(0, 99) < idle_pct) skip_cycle();
    pick = $urandom_range(0, 9);
    if (pick == 0) h = $urandom_range(HUE_LIMIT + 1, HUE_MAX);
    else if (pick == 1) h = $urandom_range(0, HUE_MAX);
    else h = $urandom_range(0, HUE_LIMIT);
    pick = $urandom_range(0, 15);
    s = (pick == 0) ? 0 : (pick == 1) ? FULL_SCALE : $urandom_range(0, FULL_SCALE);
    pick = $urandom_range(0, 15);
    v = (pick == 0) ? 0 : (pick == 1) ? FULL_SCALE : $urandom_range(0, FULL_SCALE);
    push_pixel(h, s, v);
  endtask

  task automatic test_directed_corners();
    push_pixel(0, 0, 0);
    push_pixel(0, FULL_SCALE, FULL_SCALE);
    push_pixel(0, 0, FULL_SCALE);
    push_pixel(HUE_LIMIT, FULL_SCALE, FULL_SCALE);
    push_pixel(HUE_LIMIT, 0, FULL_SCALE);
    push_pixel(HUE_LIMIT + 1, FULL_SCALE, FULL_SCALE);
    push_pixel(HUE_MAX, FULL_SCALE, FULL_SCALE);
    push_pixel(HUE_MAX, 0, 0);
    push_pixel(400, 128, 77);
    push_pixel(59, FULL_SCALE, FULL_SCALE);
    push_pixel(60, FULL_SCALE, FULL_SCALE);
    push_pixel(119, 1, 254);
    push_pixel(120, FULL_SCALE, 128);
    push_pixel(180, 128, FULL_SCALE);
    push_pixel(240, FULL_SCALE, 200);
    push_pixel(300, 200, FULL_SCALE);
    push_pixel(30, 170, 85);
    push_pixel(90, 85, 170);
    push_pixel(150, FULL_SCALE, 1);
    push_pixel(210, 1, FULL_SCALE);
    push_pixel(270, 128, 128);
    push_pixel(330, 254, 254);
    wait_drain();
  endtask

  task automatic test_stream_back_to_back();
    repeat (400) push_random_pixel(0);
  endtask

  task automatic test_stream_sparse();
    repeat (350) push_random_pixel(46);
  endtask

  task automatic test_stream_light_gaps();
    repeat (350) push_random_pixel(9);
  endtask

  task automatic test_drain_pause();
    repeat (50) push_random_pixel(0);
    wait_drain();
    repeat (50) push_random_pixel(20);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_stream_back_to_back();
    test_stream_sparse();
    test_stream_light_gaps();
    test_drain_pause();
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_rgb.size() != 0) report_mismatch("leftover expected beats",
                                                 0, pending_rgb.size());
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/hsv2rgb_pkg.sv
design/hsv2rgb_min.sv
design/hsv2rgb_rise.sv
design/hsv2rgb_mux.sv
design/hsv_to_rgb_converter.sv
design/hsv2rgb_checker.sv
verif/tb_top.sv
